### src/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg: shared types and codes of the styled line rasterizer
// Holds the job record that travels from the front end to the back end,
// the operation codes and the pixel visibility helper.
// ----------------------------------------------------------------------------
`default_nettype none

package slr_pkg;

    // Item kinds.
    localparam logic KIND_DRAW = 1'b0;
    localparam logic KIND_TEST = 1'b1;

    // Line styles.
    localparam logic [1:0] STYLE_NORMAL = 2'd0;
    localparam logic [1:0] STYLE_DOT    = 2'd1;
    localparam logic [1:0] STYLE_THICK  = 2'd2;
    localparam logic [1:0] STYLE_BROKEN = 2'd3;

    // Write modes.
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_SET   = 2'd1;
    localparam logic [1:0] MODE_XOR   = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_MIN_COORD     = 1'b0;
    localparam logic CFG_DEFAULT_STYLE = 1'b1;

    // Widths of the input coordinates and of the internal positions.
    localparam int COORD_W = 10;
    localparam int POS_W   = 11;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [POS_W-1:0]   pos_t;

    // Classified item as handed from the front end to the back end.
    typedef struct packed {
        logic       kind;
        coord_t     start_x;
        coord_t     start_y;
        coord_t     end_x;
        coord_t     end_y;
        logic [1:0] style;
        logic [1:0] mode;
        logic       reject;
    } job_t;

    // True when a pixel lies inside the visible area.
    function automatic logic on_screen(input pos_t px, input pos_t py,
                                       input logic min_c, input int w,
                                       input int h);
        logic signed [POS_W:0] ex;
        logic signed [POS_W:0] ey;
        logic signed [POS_W:0] lo;
        logic signed [POS_W:0] hx;
        logic signed [POS_W:0] hy;
        ex = {px[POS_W-1], px};
        ey = {py[POS_W-1], py};
        lo = {{POS_W{1'b0}}, min_c};
        hx = (POS_W+1)'(w - 1);
        hy = (POS_W+1)'(h - 1);
        return (ex >= lo) && (ex <= hx) && (ey >= lo) && (ey <= hy);
    endfunction

endpackage

`default_nettype wire

### src/slr_if.sv
// ----------------------------------------------------------------------------
// slr_if: handshake channels of the styled line rasterizer
// An item channel carrying draw and test requests, and a result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface slr_item_if;
    logic              valid;
    logic              ready;
    logic              kind;
    logic signed [9:0] start_x;
    logic signed [9:0] start_y;
    logic signed [9:0] end_x;
    logic signed [9:0] end_y;
    logic signed [2:0] line_style;
    logic [1:0]        write_mode;

    modport source (output valid, kind, start_x, start_y, end_x, end_y,
                    line_style, write_mode, input ready);
    modport sink (input valid, kind, start_x, start_y, end_x, end_y,
                  line_style, write_mode, output ready);
endinterface

interface slr_result_if;
    logic valid;
    logic ready;
    logic pixel_value;
    logic rejected;

    modport source (output valid, pixel_value, rejected, input ready);
    modport sink (input valid, pixel_value, rejected, output ready);
endinterface

`default_nettype wire

### src/styled_line_rasterizer.sv
// ----------------------------------------------------------------------------
// styled_line_rasterizer: styled Bresenham lines into a one-bit frame
// Top level: configuration registers, front end, job queue and line walker.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel takes draw and test requests; each transfer yields
//   exactly one transfer on the result channel, in order. Registers are
//   written through cfg_we / cfg_index / cfg_data; the user must write them
//   only while the block is idle, which the block itself does not enforce.
//   After reset the frame memory is cleared one pixel per cycle, all
//   SCREEN_WIDTH * SCREEN_HEIGHT pixels (8192 by default); no item is taken
//   during that pass.
//   A test item reads one pixel of the frame memory. A draw item walks N+1
//   points, with one pixel per point for a single-pixel style and up to four
//   for the block styles: every written pixel is a read then a write of the
//   frame memory, whose read data is registered, and each point has one
//   stepping state. A rejected item goes straight to the result.
//   Results wait in an output register; while the receiver stalls the
//   two-entry job queue keeps taking items until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module styled_line_rasterizer #(
    parameter int SCREEN_WIDTH   = 128,
    parameter int SCREEN_HEIGHT  = 64,
    parameter int ENDPOINT_LIMIT = 500
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [1:0] cfg_data,
    slr_item_if.sink        item,
    slr_result_if.source    result
);
    import slr_pkg::*;

    logic       min_coord_reg;
    logic [1:0] default_style_reg;
    logic       clearing;
    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    job_t       q_din;
    job_t       q_dout;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_coord_reg     <= 1'b0;
            default_style_reg <= STYLE_NORMAL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_COORD:     min_coord_reg     <= cfg_data[0];
                CFG_DEFAULT_STYLE: default_style_reg <= cfg_data;
                default:           min_coord_reg     <= min_coord_reg;
            endcase
        end
    end

    slr_front #(
        .SCREEN_WIDTH   (SCREEN_WIDTH),
        .SCREEN_HEIGHT  (SCREEN_HEIGHT),
        .ENDPOINT_LIMIT (ENDPOINT_LIMIT)
    ) u_front (
        .item          (item),
        .min_coord     (min_coord_reg),
        .default_style (default_style_reg),
        .clearing      (clearing),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (q_din)
    );

    slr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    slr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .min_coord (min_coord_reg),
        .job       (q_dout),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .result    (result)
    );

`ifndef ASSERT_OFF
    // No transfer is taken while the frame is being cleared.
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !item.ready)
        else $error("item accepted during frame clear");

    // The walker only takes a job that is really queued.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job taken from an empty queue");

    // A default style write lands in its register.
    a_cfg_style: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == CFG_DEFAULT_STYLE) |=>
            (default_style_reg == $past(cfg_data)))
        else $error("default style write lost");
`endif

endmodule

`default_nettype wire

### src/slr_ram.sv
// ----------------------------------------------------------------------------
// slr_ram: generic simple dual-port RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/slr_front.sv
// ----------------------------------------------------------------------------
// slr_front: item intake and classification
// Resolves the style, checks endpoints and test pixels and pushes a job.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_front #(
    parameter int SCREEN_WIDTH   = 128,
    parameter int SCREEN_HEIGHT  = 64,
    parameter int ENDPOINT_LIMIT = 500
) (
    slr_item_if.sink        item,
    input  wire logic       min_coord,
    input  wire logic [1:0] default_style,
    input  wire logic       clearing,
    input  wire logic       q_full,
    output logic            q_push,
    output slr_pkg::job_t   q_job
);
    import slr_pkg::*;

    function automatic logic in_limit(input coord_t v);
        pos_t lim;
        pos_t ext;
        lim = POS_W'(ENDPOINT_LIMIT);
        ext = {v[COORD_W-1], v};
        return (ext >= -lim) && (ext <= lim);
    endfunction

    logic limits_ok;
    logic test_ok;

    // Accept only while the queue has room and the frame is not being cleared.
    assign item.ready = !q_full && !clearing;
    assign q_push     = item.valid && item.ready;

    assign limits_ok = in_limit(item.start_x) && in_limit(item.start_y) &&
                       in_limit(item.end_x) && in_limit(item.end_y);
    assign test_ok   = on_screen({item.start_x[COORD_W-1], item.start_x},
                                 {item.start_y[COORD_W-1], item.start_y},
                                 min_coord, SCREEN_WIDTH, SCREEN_HEIGHT);

    // Build the job record.
    always_comb
    begin
        q_job.kind    = item.kind;
        q_job.start_x = item.start_x;
        q_job.start_y = item.start_y;
        q_job.end_x   = item.end_x;
        q_job.end_y   = item.end_y;
        q_job.style   = item.line_style[2] ? default_style : item.line_style[1:0];
        q_job.mode    = item.write_mode;
        q_job.reject  = (item.kind == KIND_TEST) ? !test_ok : !limits_ok;
    end

endmodule

`default_nettype wire

### src/slr_queue.sv
// ----------------------------------------------------------------------------
// slr_queue: two-entry job queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire slr_pkg::job_t din,
    output logic               full,
    input  wire logic          pop,
    output slr_pkg::job_t      dout,
    output logic               empty
);
    import slr_pkg::*;

    job_t       entry_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign dout  = entry_reg[rptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Payload storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

### src/slr_back.sv
// ----------------------------------------------------------------------------
// slr_back: line walker and frame memory
// Clears the frame after reset, walks Bresenham lines pixel by pixel with a
// read-modify-write of the frame memory, serves pixel tests and posts results.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_back #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          min_coord,
    input  wire slr_pkg::job_t job,
    input  wire logic          q_empty,
    output logic               q_pop,
    output logic               clearing,
    slr_result_if.source       result
);
    import slr_pkg::*;

    localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_TEST_RD,
        S_TEST_DATA,
        S_PIX_RD,
        S_PIX_WR,
        S_STEP,
        S_FIN
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    pos_t              x_reg;
    pos_t              y_reg;
    logic signed [1:0] stepx_reg;
    logic signed [1:0] stepy_reg;
    logic [POS_W-1:0]  maj_reg;
    logic [POS_W-1:0]  min_reg;
    logic signed [POS_W:0] j_reg;
    logic [POS_W-1:0]  k_reg;
    logic              xmaj_reg;
    logic [1:0]        style_reg;
    logic [1:0]        mode_reg;
    logic              par_reg;
    logic [1:0]        mod3_reg;
    logic [1:0]        blk_reg;
    pos_t              hist_x_reg [4];
    pos_t              hist_y_reg [4];
    logic              res_pix_reg;
    logic              res_rej_reg;
    logic              out_valid_reg;
    logic              out_pix_reg;
    logic              out_rej_reg;

    // Line setup values for the job at the head of the queue.
    pos_t              dxs;
    pos_t              dys;
    logic [POS_W-1:0]  wx;
    logic [POS_W-1:0]  wy;
    logic              xmaj_new;

    // Current pixel.
    logic              block_style;
    logic              draw_pt;
    pos_t              cx;
    pos_t              cy;
    logic              hit;
    logic              do_write;
    logic [ADDR_W-1:0] pix_addr;
    logic              out_free;
    logic signed [POS_W:0] jt;

    // RAM ports.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic              ram_rdata;

    slr_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign result.valid       = out_valid_reg;
    assign result.pixel_value = out_pix_reg;
    assign result.rejected    = out_rej_reg;

    assign clearing = (state_reg == S_CLEAR);
    assign out_free = !out_valid_reg || result.ready;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;

    // Line setup from the queued job.
    always_comb
    begin
        dxs = pos_t'({job.end_x[COORD_W-1], job.end_x}) -
              pos_t'({job.start_x[COORD_W-1], job.start_x});
        dys = pos_t'({job.end_y[COORD_W-1], job.end_y}) -
              pos_t'({job.start_y[COORD_W-1], job.start_y});
        wx  = dxs[POS_W-1] ? POS_W'(-dxs) : POS_W'(dxs);
        wy  = dys[POS_W-1] ? POS_W'(-dys) : POS_W'(dys);
        xmaj_new = (job.style == STYLE_DOT) ? (wx > wy) : (wx >= wy);
    end

    // Pixel of the current point, block offset and write decision.
    always_comb
    begin
        block_style = (style_reg == STYLE_THICK) || (style_reg == STYLE_BROKEN);
        unique case (style_reg)
            STYLE_NORMAL: draw_pt = 1'b1;
            STYLE_DOT:    draw_pt = !par_reg;
            STYLE_THICK:  draw_pt = 1'b1;
            STYLE_BROKEN: draw_pt = (mod3_reg == 2'd0);
            default:      draw_pt = 1'b1;
        endcase
        cx = block_style ? x_reg - pos_t'(blk_reg[1]) : x_reg;
        cy = block_style ? y_reg - pos_t'(blk_reg[0]) : y_reg;
        hit = 1'b0;
        for (int h = 0; h < 4; h++)
        begin
            if (hist_x_reg[h] == cx && hist_y_reg[h] == cy)
            begin
                hit = 1'b1;
            end
        end
        hit = hit && block_style && (mode_reg == MODE_XOR);
        do_write = on_screen(cx, cy, min_coord, SCREEN_WIDTH, SCREEN_HEIGHT) &&
                   (mode_reg != MODE_NONE) && !hit;
        pix_addr = ADDR_W'(int'(cy[POS_W-2:0]) * SCREEN_WIDTH +
                           int'(cx[POS_W-2:0]));
        jt = j_reg - $signed({1'b0, min_reg});
    end

    // Frame memory access.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pix_addr;
        ram_wdata = 1'b0;
        ram_raddr = pix_addr;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
        end
        else if (state_reg == S_PIX_WR)
        begin
            ram_we = 1'b1;
            unique case (mode_reg)
                MODE_CLEAR: ram_wdata = 1'b0;
                MODE_SET:   ram_wdata = 1'b1;
                MODE_XOR:   ram_wdata = !ram_rdata;
                MODE_NONE:  ram_wdata = ram_rdata;
                default:    ram_wdata = ram_rdata;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int h = 0; h < 4; h++)
            begin
                hist_x_reg[h] <= '1;
                hist_y_reg[h] <= '1;
            end
        end
        else
        begin
            // The finishing state reloads the output register itself.
            if (out_valid_reg && result.ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        res_pix_reg <= 1'b0;
                        res_rej_reg <= job.reject;
                        x_reg       <= {job.start_x[COORD_W-1], job.start_x};
                        y_reg       <= {job.start_y[COORD_W-1], job.start_y};
                        style_reg   <= job.style;
                        mode_reg    <= job.mode;
                        stepx_reg   <= dxs[POS_W-1] ? -2'sd1 : ((dxs != '0) ? 2'sd1 : 2'sd0);
                        stepy_reg   <= dys[POS_W-1] ? -2'sd1 : ((dys != '0) ? 2'sd1 : 2'sd0);
                        xmaj_reg    <= xmaj_new;
                        maj_reg     <= xmaj_new ? wx : wy;
                        min_reg     <= xmaj_new ? wy : wx;
                        j_reg       <= $signed({1'b0, (xmaj_new ? wx : wy) >> 1});
                        k_reg       <= '0;
                        par_reg     <= 1'b0;
                        mod3_reg    <= 2'd0;
                        blk_reg     <= 2'd0;
                        if (job.reject)
                        begin
                            state_reg <= S_FIN;
                        end
                        else if (job.kind == KIND_TEST)
                        begin
                            state_reg <= S_TEST_RD;
                        end
                        else
                        begin
                            for (int h = 0; h < 4; h++)
                            begin
                                hist_x_reg[h] <= '1;
                            end
                            state_reg <= S_PIX_RD;
                        end
                    end
                end
                S_TEST_RD:
                begin
                    state_reg <= S_TEST_DATA;
                end
                S_TEST_DATA:
                begin
                    res_pix_reg <= ram_rdata;
                    state_reg   <= S_FIN;
                end
                S_PIX_RD, S_PIX_WR:
                begin
                    if (state_reg == S_PIX_RD && draw_pt && do_write)
                    begin
                        state_reg <= S_PIX_WR;
                    end
                    else if (draw_pt && block_style && blk_reg != 2'd3)
                    begin
                        blk_reg   <= blk_reg + 2'd1;
                        state_reg <= S_PIX_RD;
                    end
                    else
                    begin
                        if (draw_pt && block_style && mode_reg == MODE_XOR)
                        begin
                            for (int h = 0; h < 4; h++)
                            begin
                                hist_x_reg[h] <= x_reg - pos_t'(h / 2);
                                hist_y_reg[h] <= y_reg - pos_t'(h % 2);
                            end
                        end
                        blk_reg   <= 2'd0;
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    if (k_reg == maj_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        k_reg    <= k_reg + POS_W'(1);
                        par_reg  <= !par_reg;
                        mod3_reg <= (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
                        if (jt < 0)
                        begin
                            j_reg <= jt + $signed({1'b0, maj_reg});
                        end
                        else
                        begin
                            j_reg <= jt;
                        end
                        if (xmaj_reg)
                        begin
                            x_reg <= x_reg + pos_t'(stepx_reg);
                            if (jt < 0)
                            begin
                                y_reg <= y_reg + pos_t'(stepy_reg);
                            end
                        end
                        else
                        begin
                            y_reg <= y_reg + pos_t'(stepy_reg);
                            if (jt < 0)
                            begin
                                x_reg <= x_reg + pos_t'(stepx_reg);
                            end
                        end
                        state_reg <= S_PIX_RD;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pix_reg   <= res_pix_reg;
                        out_rej_reg   <= res_rej_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
